// ===== hw/rtl/rational_arithmetic_unit_macros.svh =====
// assertion macros for the rational arithmetic unit checker
// no dependencies
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
// implication checked on every clock edge out of reset
`define RAU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define RAU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== hw/rtl/rau_pkg.sv =====
// shared types and constants for the rational arithmetic unit
// no dependencies
package rau_pkg;
    localparam int WIDTH = 32;
    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_SUB = 3'd1;
    localparam logic [2:0] CMD_MUL = 3'd2;
    localparam logic [2:0] CMD_DIV = 3'd3;
    localparam logic [2:0] CMD_CMP = 3'd4;
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIVZ = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;
    localparam logic [1:0] ORD_LT  = 2'd0;
    localparam logic [1:0] ORD_EQ  = 2'd1;
    localparam logic [1:0] ORD_GT  = 2'd2;

    // classified item handed from front to back
    typedef struct packed {
        logic        direct;   // result known, no reduction needed
        logic [31:0] d_num;
        logic [30:0] d_den;
        logic [1:0]  d_status;
        logic [1:0]  d_order;
        logic [2:0]  cmd;
        logic        neg_b;    // divide by negative divisor
        logic [31:0] a_num;
        logic [30:0] a_den;
        logic [31:0] b_num;
        logic [30:0] b_den;
    } t_item;

    typedef struct packed {
        logic [31:0] num;
        logic [30:0] den;
        logic [1:0]  status;
        logic [1:0]  order;
    } t_result;
endpackage

// ===== hw/rtl/rau_front.sv =====
// front end: accepts items, classifies special cases, writes a short queue
// depends on rau_pkg
module rau_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [2:0]           i_cmd,
    input  logic signed [31:0]   i_a_num,
    input  logic [30:0]          i_a_den,
    input  logic signed [31:0]   i_b_num,
    input  logic [30:0]          i_b_den,
    output logic                 o_q_valid,
    input  logic                 i_q_pop,
    output rau_pkg::t_item       o_q_item
);
    // two-entry queue
    rau_pkg::t_item r_mem [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    rau_pkg::t_item w_it;
    logic           w_push;

    always_comb begin
        w_it = '0;
        w_it.cmd = i_cmd;
        w_it.a_num = i_a_num;
        w_it.a_den = i_a_den;
        w_it.b_num = i_b_num;
        w_it.b_den = i_b_den;
        w_it.neg_b = i_b_num[31];
        w_it.d_den = 31'd1;
        if (i_cmd == rau_pkg::CMD_DIV && i_b_num == '0) begin
            w_it.direct = 1'b1;
            w_it.d_num = i_a_num;
            w_it.d_den = i_a_den;
            w_it.d_status = rau_pkg::ST_DIVZ;
        end else if (i_cmd > rau_pkg::CMD_CMP) begin
            w_it.direct = 1'b1;
        end else if (i_cmd != rau_pkg::CMD_CMP &&
                     (i_a_den == '0 || i_b_den == '0)) begin
            w_it.direct = 1'b1;
        end
    end

    assign o_ready   = (r_cnt != 2'd2);
    assign w_push    = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= w_it;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_q_pop};
        end
    end
endmodule

// ===== hw/rtl/rau_back.sv =====
// back end: cross-products, binary gcd, scaling divide, fit check
// depends on rau_pkg
module rau_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    output logic                 o_q_pop,
    input  rau_pkg::t_item       i_q_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output rau_pkg::t_result     o_res
);
    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_MUL1 = 9'b000000010,
        S_MUL2 = 9'b000000100,
        S_FORM = 9'b000001000,
        S_GCD  = 9'b000010000,
        S_DIVN = 9'b000100000,
        S_DIVD = 9'b001000000,
        S_FIT  = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

    t_state         r_st;
    rau_pkg::t_item r_it;
    logic signed [63:0] r_p1, r_p2;
    logic [63:0]    r_dp;
    logic           r_neg;
    logic [63:0]    r_mag, r_den;      // values to reduce
    logic [63:0]    r_ga, r_gb;        // gcd operands
    logic [5:0]     r_sh;              // common power of two
    logic [63:0]    r_g;               // gcd
    logic [63:0]    r_q, r_rem, r_dvd;
    logic [5:0]     r_bit;
    logic [63:0]    r_qmag;
    rau_pkg::t_result r_res;

    localparam logic [63:0] LIM = 64'd1 << (rau_pkg::WIDTH - 1);

    logic signed [63:0] w_num;
    logic [63:0] w_gdiff;
    logic [64:0] w_trial;
    logic [63:0] w_rsh;
    logic        w_ov;

    always_comb begin
        unique case (r_it.cmd)
            rau_pkg::CMD_SUB: w_num = r_p1 - r_p2;
            rau_pkg::CMD_MUL: w_num = r_p2;
            rau_pkg::CMD_DIV: w_num = r_it.neg_b ? -r_p1 : r_p1;
            default:          w_num = r_p1 + r_p2;
        endcase
        w_gdiff = (r_ga > r_gb) ? r_ga - r_gb : r_gb - r_ga;
        w_rsh   = {r_rem[62:0], r_dvd[r_bit]};
        w_trial = {1'b0, w_rsh} - {1'b0, r_g};
        w_ov    = (r_den > LIM - 64'd1) ||
                  (r_neg ? r_qmag > LIM : r_qmag > LIM - 64'd1);
    end

    assign o_q_pop = (r_st == S_IDLE) && i_q_valid;
    assign o_valid = (r_st == S_OUT);
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
        end else begin
            unique case (r_st)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_it <= i_q_item;
                        if (i_q_item.direct) begin
                            r_res.num    <= i_q_item.d_num;
                            r_res.den    <= i_q_item.d_den;
                            r_res.status <= i_q_item.d_status;
                            r_res.order  <= i_q_item.d_order;
                            r_st <= S_OUT;
                        end else begin
                            r_st <= S_MUL1;
                        end
                    end
                end
                S_MUL1: begin
                    // a_num*b_den and b_num*a_den (a_num*b_num for multiply)
                    r_p1 <= $signed(r_it.a_num) * $signed({1'b0, r_it.b_den});
                    r_p2 <= (r_it.cmd == rau_pkg::CMD_MUL)
                        ? $signed(r_it.a_num) * $signed(r_it.b_num)
                        : $signed(r_it.b_num) * $signed({1'b0, r_it.a_den});
                    r_st <= S_MUL2;
                end
                S_MUL2: begin
                    if (r_it.cmd == rau_pkg::CMD_DIV)
                        r_dp <= {33'd0, r_it.a_den} *
                            (r_it.neg_b ? 64'd0 - {{32{r_it.b_num[31]}}, r_it.b_num}
                                        : {32'd0, r_it.b_num});
                    else
                        r_dp <= {33'd0, r_it.a_den} * {33'd0, r_it.b_den};
                    r_st <= S_FORM;
                end
                S_FORM: begin
                    r_res.num <= '0;
                    r_res.den <= 31'd1;
                    r_res.status <= rau_pkg::ST_OK;
                    if (r_it.cmd == rau_pkg::CMD_CMP) begin
                        r_res.order <= (r_p1 < r_p2) ? rau_pkg::ORD_LT :
                            (r_p1 == r_p2) ? rau_pkg::ORD_EQ : rau_pkg::ORD_GT;
                        r_st <= S_OUT;
                    end else begin
                        r_res.order <= rau_pkg::ORD_LT;
                        if (w_num == '0) begin
                            r_st <= S_OUT;
                        end else begin
                            r_neg <= w_num[63];
                            r_mag <= w_num[63] ? 64'd0 - w_num : w_num;
                            r_den <= r_dp;
                            r_ga  <= w_num[63] ? 64'd0 - w_num : w_num;
                            r_gb  <= r_dp;
                            r_sh  <= '0;
                            r_st  <= S_GCD;
                        end
                    end
                end
                S_GCD: begin
                    // binary gcd, one step per cycle
                    if (r_ga == r_gb) begin
                        r_g <= r_ga << r_sh;
                        r_dvd <= r_mag;
                        r_rem <= '0;
                        r_q <= '0;
                        r_bit <= 6'd63;
                        r_st <= S_DIVN;
                    end else if (!r_ga[0] && !r_gb[0]) begin
                        r_ga <= r_ga >> 1;
                        r_gb <= r_gb >> 1;
                        r_sh <= r_sh + 6'd1;
                    end else if (!r_ga[0]) begin
                        r_ga <= r_ga >> 1;
                    end else if (!r_gb[0]) begin
                        r_gb <= r_gb >> 1;
                    end else if (r_ga > r_gb) begin
                        r_ga <= w_gdiff;
                    end else begin
                        r_gb <= w_gdiff;
                    end
                end
                S_DIVN, S_DIVD: begin
                    // restoring divide by gcd, one quotient bit per cycle
                    if (r_bit == '0) begin
                        r_bit <= 6'd63;
                        r_rem <= '0;
                        if (r_st == S_DIVN) begin
                            r_qmag <= {r_q[62:0], !w_trial[64]};
                            r_dvd <= r_den;
                            r_q <= '0;
                            r_st <= S_DIVD;
                        end else begin
                            r_den <= {r_q[62:0], !w_trial[64]};
                            r_st <= S_FIT;
                        end
                    end else begin
                        r_bit <= r_bit - 6'd1;
                        if (!w_trial[64]) begin
                            r_rem <= w_trial[63:0];
                            r_q <= {r_q[62:0], 1'b1};
                        end else begin
                            r_rem <= w_rsh;
                            r_q <= {r_q[62:0], 1'b0};
                        end
                    end
                end
                S_FIT: begin
                    if (w_ov) begin
                        r_res.status <= rau_pkg::ST_OVF;
                    end else begin
                        r_res.num <= r_neg ? 32'd0 - r_qmag[31:0] : r_qmag[31:0];
                        r_res.den <= r_den[30:0];
                    end
                    r_st <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== hw/rtl/rational_arithmetic_unit.sv =====
// rational arithmetic unit top level: front classifier, queue, reduction engine
// depends on rau_pkg, rau_front, rau_back
// one item at a time through the back end: a divide by zero, a bad opcode or
// a zero denominator (other than on compare) goes straight from idle to the
// output state; compare and zero results pass through the two multiply states
// and the form state, and a reduced result adds the binary gcd steps (one shift
// or one subtract per cycle), the two 64-bit bit-serial divisions by the gcd
// on the shared divider and the fit check; the front queue holds two further
// transactions, so the source is stalled only once both entries are full
module rational_arithmetic_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_cmd,
    input  logic signed [31:0] i_a_num,
    input  logic [30:0]        i_a_den,
    input  logic signed [31:0] i_b_num,
    input  logic [30:0]        i_b_den,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_res_num,
    output logic [30:0]        o_res_den,
    output logic [1:0]         o_status,
    output logic [1:0]         o_order
);
    logic             w_q_valid, w_q_pop;
    rau_pkg::t_item   w_q_item;
    rau_pkg::t_result w_res;

    // front: classify special cases and queue
    rau_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_cmd(i_cmd), .i_a_num(i_a_num), .i_a_den(i_a_den),
        .i_b_num(i_b_num), .i_b_den(i_b_den),
        .o_q_valid(w_q_valid), .i_q_pop(w_q_pop), .o_q_item(w_q_item)
    );

    // back: multiply, reduce, fit check, output register
    rau_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(w_q_valid), .o_q_pop(w_q_pop), .i_q_item(w_q_item),
        .o_valid(o_valid), .i_ready(i_ready), .o_res(w_res)
    );

    assign o_res_num = w_res.num;
    assign o_res_den = w_res.den;
    assign o_status  = w_res.status;
    assign o_order   = w_res.order;
endmodule

// ===== hw/rtl/rau_checker.sv =====
// port-level checker for the rational arithmetic unit, bound to the top level
// depends on rational_arithmetic_unit_macros.svh and rau_pkg
`include "rational_arithmetic_unit_macros.svh"
module rau_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [30:0] o_res_den,
    input logic [1:0]  o_status,
    input logic [1:0]  o_order
);
    `RAU_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_res_den))
    `RAU_ASSERT_IMP(a_stat, i_clk, i_rst_n, o_valid, o_status <= rau_pkg::ST_OVF)
    `RAU_ASSERT_IMP(a_ovf, i_clk, i_rst_n, o_valid && o_status == rau_pkg::ST_OVF, o_res_den == 31'd1)
    `RAU_ASSERT_IMP(a_ord, i_clk, i_rst_n, o_valid && o_order != rau_pkg::ORD_LT, o_status == rau_pkg::ST_OK)
endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_ready(i_ready),
    .o_res_den(o_res_den), .o_status(o_status), .o_order(o_order)
);
